// ===== rtl/mxt_pkg.sv =====
// Shared types and constants for the maximum subarray XOR trie block.
`timescale 1ns / 1ps

package mxt_pkg;

  // Width of the element and result fields on the stream ports.
  localparam int DATA_W = 32;

  // Default key width and node store depth.
  localparam int KEY_BITS_DEF   = 32;
  localparam int NODE_COUNT_DEF = 32768;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_BOOT,
    ST_IDLE,
    ST_INS_RD,
    ST_INS_CHK,
    ST_WR,
    ST_LEAF,
    ST_QRY_RD,
    ST_QRY_CHK,
    ST_DONE
  } state_t;

  // Control shared by every cell of the key chain.
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  // Node store access command.
  typedef struct packed {
    logic re;
    logic we;
  } mem_cmd_t;

endpackage

// ===== rtl/mxt_cell.sv =====
// One bit cell of the key chain: holds a key bit and a found bit and passes both upward.
`timescale 1ns / 1ps

module mxt_cell (
  input  logic               clk,
  input  mxt_pkg::cell_ctrl_t ctrl,
  input  logic               ld_key,
  input  logic               key_in,
  input  logic               fnd_in,
  output logic               key_out,
  output logic               fnd_out
);
  import mxt_pkg::*;

  logic key_r;
  logic fnd_r;

  // A load takes a fresh key bit and clears the found bit; a shift takes the
  // lower neighbor's bits.
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      key_r <= ld_key;
      fnd_r <= 1'b0;
    end else if (ctrl.shift) begin
      key_r <= key_in;
      fnd_r <= fnd_in;
    end
  end

  assign key_out = key_r;
  assign fnd_out = fnd_r;

endmodule

// ===== rtl/mxt_node_mem.sv =====
// Single-port node store holding the two child links of every trie node.
`timescale 1ns / 1ps

module mxt_node_mem #(
  parameter int DEPTH = 32768,
  parameter int AW    = 15,
  parameter int DW    = 30
) (
  input  logic               clk,
  input  mxt_pkg::mem_cmd_t  cmd,
  input  logic [AW-1:0]      addr,
  input  logic [DW-1:0]      wdata,
  output logic [DW-1:0]      rdata
);
  import mxt_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // One access per cycle; read data is registered.
  always_ff @(posedge clk) begin
    if (cmd.we) begin
      mem[addr] <= wdata;
    end else if (cmd.re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/max_subarray_xor_trie.sv =====
// Top level: maximum subarray XOR over a stream of elements using a binary trie.
`timescale 1ns / 1ps
//
// Elements arrive on the in_ stream channel, one per transaction: in_tdata
// carries the element and in_tuser marks the first element of a new array.
// Every input transaction produces exactly one output transaction: out_tdata
// is the largest XOR of any contiguous run of the current array so far and
// out_tuser is the sticky flag that the node store ran out during this array.
// Each element is handled alone: the prefix is inserted by a walk through the
// single-port node store (one node per cycle), then a second walk finds the
// best partner. A key chain of KEY_BITS cells shifts the key out top bit first
// and collects the result bits. A new element is accepted only once the block
// is back in idle after the previous element. A new array first rebuilds the
// zero prefix path. After reset the block lays down that path before in_tready
// rises. A finished result sits in an output register, so the next element is
// accepted while the receiver stalls; a second result then waits in the block
// until the output register is free.

module max_subarray_xor_trie #(
  parameter int KEY_BITS   = mxt_pkg::KEY_BITS_DEF,
  parameter int NODE_COUNT = mxt_pkg::NODE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [mxt_pkg::DATA_W-1:0] in_tdata,   // [31:0] element
  input  logic                       in_tuser,   // [0] new_array
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [mxt_pkg::DATA_W-1:0] out_tdata,  // [31:0] best_xor
  output logic                       out_tuser   // [0] overflow
);
  import mxt_pkg::*;

  localparam int NODE_BITS = $clog2(NODE_COUNT);
  localparam int NF_W      = NODE_BITS + 1;
  localparam int NF_E      = NF_W + 1;
  localparam int ENT_W     = 2 * NODE_BITS;
  localparam int LVL_W     = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

  // Sequencer and datapath registers.
  state_t                state_r, state_nxt;
  logic [NODE_BITS-1:0]  cur_r, cur_nxt;
  logic [LVL_W-1:0]      lvl_r, lvl_nxt;
  logic [NF_W-1:0]       nf_r, nf_nxt;
  logic [ENT_W-1:0]      par_r, par_nxt;
  logic                  first_r, first_nxt;
  logic                  item_r, item_nxt;
  logic                  clr_r, clr_nxt;
  logic                  dead_r, dead_nxt;
  logic [KEY_BITS-1:0]   prefix_r, prefix_nxt;
  logic [KEY_BITS-1:0]   best_r, best_nxt;
  logic                  ovf_r, ovf_nxt;
  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [DATA_W-1:0]     out_best_r, out_best_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // Key chain wiring.
  cell_ctrl_t            cell_ctrl;
  logic [KEY_BITS-1:0]   ld_key;
  logic [KEY_BITS:0]     key_link;
  logic [KEY_BITS:0]     fnd_link;
  logic                  fnd_bit;
  logic                  key_msb;
  logic [KEY_BITS-1:0]   found;

  // Node store port.
  mem_cmd_t              mem_cmd;
  logic [NODE_BITS-1:0]  mem_addr;
  logic [ENT_W-1:0]      mem_wdata;
  logic [ENT_W-1:0]      rd_data;

  // Decoded node fields and helpers.
  logic [NODE_BITS-1:0]  link0, link1, child_same, child_opp, nf_link;
  logic [ENT_W-1:0]      wr_base;
  logic [NF_E-1:0]       need_sum;
  logic                  no_room;
  logic                  in_acc, out_free, do_clr;

  // Chain of key cells: bit 0 at the bottom, the walk reads the top cell.
  assign key_link[0] = 1'b0;
  assign fnd_link[0] = fnd_bit;

  for (genvar g = 0; g < KEY_BITS; g++) begin : g_cell
    mxt_cell u_cell (
      .clk     (clk),
      .ctrl    (cell_ctrl),
      .ld_key  (ld_key[g]),
      .key_in  (key_link[g]),
      .fnd_in  (fnd_link[g]),
      .key_out (key_link[g+1]),
      .fnd_out (fnd_link[g+1])
    );
  end

  assign key_msb = key_link[KEY_BITS];
  assign found   = fnd_link[KEY_BITS:1];

  mxt_node_mem #(
    .DEPTH (NODE_COUNT),
    .AW    (NODE_BITS),
    .DW    (ENT_W)
  ) u_mem (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (rd_data)
  );

  // Child links of the node just read, seen from the current key bit.
  assign link0      = rd_data[NODE_BITS-1:0];
  assign link1      = rd_data[ENT_W-1:NODE_BITS];
  assign child_same = key_msb ? link1 : link0;
  assign child_opp  = key_msb ? link0 : link1;
  assign nf_link    = nf_r[NODE_BITS-1:0];
  assign wr_base    = first_r ? par_r : '0;

  // The missing part of a path is lvl + 1 nodes; it must fit whole.
  assign need_sum = NF_E'(lvl_r) + NF_E'(1) + NF_E'(nf_r);
  assign no_room  = need_sum > NF_E'(NODE_COUNT);

  // Handshake terms.
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign do_clr    = (state_r == ST_BOOT) || (in_acc && in_tuser);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_BOOT: begin
        state_nxt = ST_WR;
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tuser ? ST_WR : ST_INS_RD;
        end
      end
      ST_INS_RD: begin
        state_nxt = ST_INS_CHK;
      end
      ST_INS_CHK: begin
        if (child_same != '0) begin
          if (lvl_r == '0) begin
            state_nxt = ST_QRY_RD;
          end
        end else if (no_room) begin
          state_nxt = ST_QRY_RD;
        end else begin
          state_nxt = ST_WR;
        end
      end
      ST_WR: begin
        if (lvl_r == '0) begin
          state_nxt = ST_LEAF;
        end
      end
      // After the zero prefix path, take the pending element or go idle;
      // after an element's own path, run the query.
      ST_LEAF: begin
        if (!clr_r) begin
          state_nxt = ST_QRY_RD;
        end else if (item_r) begin
          state_nxt = ST_INS_RD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QRY_RD: begin
        state_nxt = ST_QRY_CHK;
      end
      ST_QRY_CHK: begin
        if (lvl_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_BOOT;
      end
    endcase
  end

  // Datapath, key chain and node store control.
  always_comb begin
    cur_nxt        = cur_r;
    lvl_nxt        = lvl_r;
    nf_nxt         = nf_r;
    par_nxt        = par_r;
    first_nxt      = first_r;
    item_nxt       = item_r;
    clr_nxt        = clr_r;
    dead_nxt       = dead_r;
    prefix_nxt     = prefix_r;
    best_nxt       = best_r;
    ovf_nxt        = ovf_r;
    out_best_nxt   = out_best_r;
    out_ovf_nxt    = out_ovf_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    cell_ctrl      = '0;
    ld_key         = prefix_r;
    fnd_bit        = 1'b0;
    mem_cmd        = '0;
    mem_addr       = cur_r;
    mem_wdata      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser) begin
            prefix_nxt = in_tdata[KEY_BITS-1:0];
            item_nxt   = 1'b1;
          end else begin
            prefix_nxt = prefix_r ^ in_tdata[KEY_BITS-1:0];
          end
        end
      end
      // Start a walk at the root with the current prefix in the chain.
      ST_INS_RD, ST_QRY_RD: begin
        cell_ctrl.load = 1'b1;
        mem_cmd.re     = 1'b1;
        mem_addr       = '0;
        cur_nxt        = '0;
        lvl_nxt        = LVL_W'(KEY_BITS - 1);
        dead_nxt       = 1'b0;
      end
      // Follow the key down until a link is missing; then set up the new nodes or flag an overflow.
      ST_INS_CHK: begin
        if (child_same != '0) begin
          cur_nxt         = child_same;
          mem_cmd.re      = 1'b1;
          mem_addr        = child_same;
          cell_ctrl.shift = 1'b1;
          if (lvl_r != '0) begin
            lvl_nxt = lvl_r - LVL_W'(1);
          end
        end else if (no_room) begin
          ovf_nxt = 1'b1;
        end else begin
          par_nxt   = rd_data;
          first_nxt = 1'b1;
        end
      end
      // Hang a freshly allocated node under the current one.
      ST_WR: begin
        mem_cmd.we      = 1'b1;
        mem_wdata       = key_msb ? {nf_link, wr_base[NODE_BITS-1:0]}
                                  : {wr_base[ENT_W-1:NODE_BITS], nf_link};
        cur_nxt         = nf_link;
        nf_nxt          = nf_r + NF_W'(1);
        first_nxt       = 1'b0;
        cell_ctrl.shift = 1'b1;
        if (lvl_r != '0) begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      // The last node of a path has no children.
      ST_LEAF: begin
        mem_cmd.we = 1'b1;
        mem_wdata  = '0;
        item_nxt   = 1'b0;
        clr_nxt    = 1'b0;
      end
      // Prefer the opposite bit at each level; record which way was taken.
      ST_QRY_CHK: begin
        cell_ctrl.shift = 1'b1;
        mem_cmd.re      = 1'b1;
        if (lvl_r != '0) begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
        if (!dead_r) begin
          if (child_opp != '0) begin
            fnd_bit  = 1'b1;
            cur_nxt  = child_opp;
            mem_addr = child_opp;
          end else if (child_same != '0) begin
            cur_nxt  = child_same;
            mem_addr = child_same;
          end else begin
            dead_nxt = 1'b1;
          end
        end
      end
      // Fold the candidate into the running best and hand out the result.
      ST_DONE: begin
        if (out_free) begin
          best_nxt       = (found > best_r) ? found : best_r;
          out_best_nxt   = DATA_W'(best_nxt);
          out_ovf_nxt    = ovf_r;
          out_tvalid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Empty the store and lay down the zero prefix path from the root.
    if (do_clr) begin
      cell_ctrl.load = 1'b1;
      ld_key         = '0;
      cur_nxt        = '0;
      par_nxt        = '0;
      first_nxt      = 1'b1;
      clr_nxt        = 1'b1;
      nf_nxt         = NF_W'(1);
      lvl_nxt        = LVL_W'(KEY_BITS - 1);
      best_nxt       = '0;
      ovf_nxt        = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_BOOT;
      out_tvalid_r <= 1'b0;
      item_r       <= 1'b0;
      clr_r        <= 1'b0;
      ovf_r        <= 1'b0;
      nf_r         <= NF_W'(1);
      prefix_r     <= '0;
      best_r       <= '0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      item_r       <= item_nxt;
      clr_r        <= clr_nxt;
      ovf_r        <= ovf_nxt;
      nf_r         <= nf_nxt;
      prefix_r     <= prefix_nxt;
      best_r       <= best_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    lvl_r      <= lvl_nxt;
    par_r      <= par_nxt;
    first_r    <= first_nxt;
    dead_r     <= dead_nxt;
    out_best_r <= out_best_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_best_r;
  assign out_tuser  = out_ovf_r;

  // The allocation pointer never passes the end of the store.
  a_nf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nf_r <= NF_W'(NODE_COUNT))
    else $error("node allocation pointer beyond store");

  // Writes only touch nodes that are already allocated.
  a_wr_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WR || state_r == ST_LEAF) |-> (NF_W'(cur_r) < nf_r))
    else $error("write to an unallocated node");

  // The overflow flag clears only when a new array starts.
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(ovf_r) |-> $past(in_tvalid && in_tready && in_tuser))
    else $error("overflow flag dropped within an array");

  // A result appears only when a query has finished.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the finish state");

  // An accepted transaction always leaves the idle state.
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != ST_IDLE))
    else $error("block stayed idle after accepting an element");

endmodule

// ===== tb/max_subarray_xor_trie_tb.sv =====
// Self-checking testbench for the maximum subarray XOR trie block.
`timescale 1ns / 1ps

module max_subarray_xor_trie_tb;
  import mxt_pkg::*;

  localparam int KEY_BITS       = KEY_BITS_DEF;
  localparam int NODE_COUNT     = NODE_COUNT_DEF;
  localparam int CYCLE_LIMIT    = 1500000;
  localparam int DRAIN_CYCLES   = 2 * KEY_BITS + 40;
  localparam int SHORT_ITEMS    = 40;
  localparam int LONG_CAP       = 1700;
  localparam int AFTER_OVERFLOW = 20;
  localparam int TAIL_ITEMS     = 6;
  localparam int DIRECTED_COUNT = 21;

  // One result transaction: running best XOR and the sticky overflow flag.
  typedef struct packed {
    logic [DATA_W-1:0] best_xor;
    logic              overflow;
  } xor_result_t;

  // One directed row; known rows carry their result typed in.
  typedef struct packed {
    logic [DATA_W-1:0] element;
    logic              new_array;
    logic              known;
    logic [DATA_W-1:0] best_xor;
    logic              overflow;
  } stim_row_t;

  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // No new array flag before the first element: continues the reset array.
    '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{32'h0000_0005, 1'b0, 1'b1, 32'h0000_0005, 1'b0},
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    // All ones, then back to a zero prefix.
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
    '{32'h0000_0001, 1'b0, 1'b1, 32'h8000_0001, 1'b0},
    // All zeros: every prefix equals the empty prefix.
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
    '{32'h0000_0000, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
    '{32'hAAAA_AAAA, 1'b0, 1'b1, 32'hAAAA_AAAA, 1'b0},
    '{32'h5555_5555, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{32'h1234_5678, 1'b1, 1'b1, 32'h1234_5678, 1'b0},
    '{32'h1234_5678, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{32'h8000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
    '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001, 1'b0},
    '{32'h0000_0002, 1'b0, 1'b1, 32'h0000_0003, 1'b0},
    '{32'h0000_0003, 1'b0, 1'b1, 32'h0000_0003, 1'b0},
    '{32'hDEAD_BEEF, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{32'hFFFF_0000, 1'b0, 1'b0, 32'h0000_0000, 1'b0},
    '{32'h0000_FFFF, 1'b1, 1'b1, 32'h0000_FFFF, 1'b0}
  };

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata;   // [31:0] element
  logic              in_tuser;   // [0] new_array
  logic              out_tvalid;
  logic              out_tready;
  logic [DATA_W-1:0] out_tdata;  // [31:0] best_xor
  logic              out_tuser;  // [0] overflow

  // Shadow trie: bits 15..0 link to child 0, bits 31..16 link to child 1.
  bit   [31:0]       trie_links [NODE_COUNT];
  int unsigned       alloc_ptr = 1;
  bit   [DATA_W-1:0] prefix_acc;
  bit   [DATA_W-1:0] best_acc;
  bit                ovf_sticky;

  xor_result_t       pending_results [$];
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       burst_left  = 0;

  max_subarray_xor_trie DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int unsigned link_of(int unsigned node, bit side);
    return side ? int'(trie_links[node][31:16]) : int'(trie_links[node][15:0]);
  endfunction

  function automatic void set_link(int unsigned node, bit side, int unsigned child);
    if (side) begin
      trie_links[node][31:16] = child[15:0];
    end else begin
      trie_links[node][15:0] = child[15:0];
    end
  endfunction

  function automatic void trie_insert(bit [DATA_W-1:0] key);
    int unsigned node;
    int unsigned child;
    int unsigned need;
    bit          gap_found;
    node      = 0;
    need      = 0;
    gap_found = 1'b0;
    // Count the nodes the path still lacks.
    for (int i = KEY_BITS - 1; i >= 0; i--) begin
      if (!gap_found) begin
        child = link_of(node, key[i]);
        if (child == 0) begin
          need      = i + 1;
          gap_found = 1'b1;
        end else begin
          node = child;
        end
      end
    end
    // A path that does not fit is dropped whole and the flag sticks.
    if (need > NODE_COUNT - alloc_ptr) begin
      ovf_sticky = 1'b1;
    end else begin
      node = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        child = link_of(node, key[i]);
        if (child == 0) begin
          child = alloc_ptr;
          alloc_ptr++;
          set_link(node, key[i], child);
        end
        node = child;
      end
    end
  endfunction

  // Greedy walk that prefers the opposite bit at every level.
  function automatic bit [DATA_W-1:0] trie_best_partner(bit [DATA_W-1:0] key);
    int unsigned       node;
    int unsigned       child;
    bit [DATA_W-1:0]   found;
    bit                stuck;
    node  = 0;
    found = '0;
    stuck = 1'b0;
    for (int i = KEY_BITS - 1; i >= 0; i--) begin
      if (!stuck) begin
        child = link_of(node, ~key[i]);
        if (child != 0) begin
          found[i] = 1'b1;
          node     = child;
        end else begin
          child = link_of(node, key[i]);
          if (child == 0) begin
            stuck = 1'b1;
          end else begin
            node = child;
          end
        end
      end
    end
    return found;
  endfunction

  // Only entries in use can hold links, so only those are cleared.
  function automatic void trie_clear();
    for (int unsigned i = 0; i < alloc_ptr; i++) begin
      trie_links[i] = '0;
    end
    alloc_ptr  = 1;
    prefix_acc = '0;
    best_acc   = '0;
    ovf_sticky = 1'b0;
    trie_insert('0);
  endfunction

  function automatic xor_result_t predict_xor(bit [DATA_W-1:0] elem, bit new_arr);
    xor_result_t     res;
    bit [DATA_W-1:0] cand;
    bit [DATA_W-1:0] key_mask;
    key_mask = DATA_W'((64'd1 << KEY_BITS) - 64'd1);
    if (new_arr) begin
      trie_clear();
    end
    prefix_acc = (prefix_acc ^ elem) & key_mask;
    trie_insert(prefix_acc);
    cand = trie_best_partner(prefix_acc);
    if (cand > best_acc) begin
      best_acc = cand;
    end
    res.best_xor = best_acc;
    res.overflow = ovf_sticky;
    return res;
  endfunction

  // Offer one element after a random gap and record its expected result.
  task automatic send_element(input logic [DATA_W-1:0] elem, input logic new_arr,
                              input logic known, input xor_result_t tabled);
    int unsigned gap;
    xor_result_t predicted;
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 63) == 0) begin
      gap        = 0;
      burst_left = $urandom_range(20, 60);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: gap = 0;
        5, 6, 7, 8:    gap = $urandom_range(1, 4);
        default:       gap = $urandom_range(10, 30);
      endcase
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= elem;
    in_tuser  <= new_arr;
    do @(posedge clk); while (!in_tready);
    predicted = predict_xor(elem, new_arr);
    pending_results = {pending_results, (known ? tabled : predicted)};
  endtask

  // Receiver pacing: ready spans alternate with stalls, mostly short.
  initial begin : sink_pacing
    int unsigned span;
    forever begin
      span = ($urandom_range(0, 15) == 0) ? 150 : $urandom_range(1, 20);
      out_tready <= 1'b1;
      repeat (span) @(posedge clk);
      case ($urandom_range(0, 99)) inside
        [0:39]:  span = 0;
        [40:84]: span = $urandom_range(1, 5);
        [85:96]: span = $urandom_range(6, 20);
        default: span = $urandom_range(40, 100);
      endcase
      if (span > 0) begin
        out_tready <= 1'b0;
        repeat (span) @(posedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin : result_check
    xor_result_t exp_res;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction: best_xor %h overflow %b",
               out_tdata, out_tuser);
        error_count++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_tdata !== exp_res.best_xor) begin
          $error("best_xor mismatch: expected %h, actual %h", exp_res.best_xor, out_tdata);
          error_count++;
        end
        if (out_tuser !== exp_res.overflow) begin
          $error("overflow mismatch: expected %b, actual %b", exp_res.overflow, out_tuser);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned       sent_short;
    int unsigned       arr_len;
    int unsigned       long_count;
    int unsigned       after_ovf;
    logic [DATA_W-1:0] elem;
    logic [DATA_W-1:0] saved_prefix;
    logic              new_arr;
    xor_result_t       tabled;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    sent_short   = 0;
    saved_prefix = '0;
    trie_clear();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed rows: extremes, zero prefixes and the reset array.
    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      tabled.best_xor = DIRECTED_ROWS[r].best_xor;
      tabled.overflow = DIRECTED_ROWS[r].overflow;
      send_element(DIRECTED_ROWS[r].element, DIRECTED_ROWS[r].new_array,
                   DIRECTED_ROWS[r].known, tabled);
    end

    // Short arrays with mixed element shapes.
    while (sent_short < SHORT_ITEMS) begin
      arr_len = $urandom_range(1, 24);
      for (int k = 0; k < arr_len; k++) begin
        case ($urandom_range(0, 5))
          0:       elem = $urandom();
          1:       elem = $urandom_range(0, 15);
          2:       elem = 32'd1 << $urandom_range(0, 31);
          3:       elem = ~(32'd1 << $urandom_range(0, 31));
          4:       elem = $urandom_range(0, 1) ? '1 : '0;
          default: elem = prefix_acc ^ saved_prefix;  // return to an earlier prefix
        endcase
        new_arr = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
        if ($urandom_range(0, 3) == 0) begin
          saved_prefix = prefix_acc;
        end
        send_element(elem, new_arr, 1'b0, '0);
        sent_short++;
      end
    end

    // One long array that fills the node store and runs on past the overflow.
    new_arr    = 1'b1;
    long_count = 0;
    after_ovf  = 0;
    while (long_count < LONG_CAP && after_ovf < AFTER_OVERFLOW) begin
      case ($urandom_range(0, 31))
        0:       elem = '0;
        1:       elem = prefix_acc ^ saved_prefix;
        default: elem = $urandom();
      endcase
      if ($urandom_range(0, 15) == 0) begin
        saved_prefix = prefix_acc;
      end
      send_element(elem, new_arr, 1'b0, '0);
      new_arr = 1'b0;
      long_count++;
      if (ovf_sticky) begin
        after_ovf++;
      end
    end

    // A fresh array must clear the sticky flag.
    for (int k = 0; k < TAIL_ITEMS; k++) begin
      send_element($urandom(), (k == 0), 1'b0, '0);
    end

    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
